/* rtl/stream_pattern_explosion_filter_core_defines.svh */
// ----------------------------------------------------------------------------
// Stream pattern explosion filter - assertion macros
// Shared property wrappers for the checker; clk and rst must be in scope.
// ----------------------------------------------------------------------------
`ifndef STREAM_PATTERN_EXPLOSION_FILTER_CORE_DEFINES_SVH
`define STREAM_PATTERN_EXPLOSION_FILTER_CORE_DEFINES_SVH

// same-cycle implication
`define SPEF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPEF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/spef_pkg.sv */
// ----------------------------------------------------------------------------
// Stream pattern explosion filter - package
// Word types, codes and constants shared by the filter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package spef_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 4096;
  localparam int unsigned MAX_PATTERN     = 16;
  localparam int unsigned PAT_CAP         = (MAX_PATTERN < 16) ? MAX_PATTERN : 16;

  localparam int unsigned CFG_IW = 2;
  localparam int unsigned CFG_DW = 64;

  // command codes
  localparam logic [1:0] MODE_PUSH  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // register indexes
  localparam logic [CFG_IW-1:0] CFG_LEN  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_LOW  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_HIGH = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  symbol;
    logic [11:0] read_index;
  } spef_in_t;

  typedef struct packed {
    logic [12:0] fill;
    logic [7:0]  read_symbol;
    logic        exploded;
    logic        overflow;
  } spef_out_t;

  // pattern as seen by the control: index of last byte and all bytes
  typedef struct packed {
    logic [3:0]       last;
    logic [15:0][7:0] bytes;
  } spef_pat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_RD
  } spef_state_t;

endpackage

`default_nettype wire

/* rtl/spef_ram.sv */
// ----------------------------------------------------------------------------
// Stream pattern explosion filter - generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module spef_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/spef_cfg.sv */
// ----------------------------------------------------------------------------
// Stream pattern explosion filter - configuration registers
// Holds pattern length and bytes, presents the effective pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module spef_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [spef_pkg::CFG_IW-1:0]   cfg_index,
  input  wire logic [spef_pkg::CFG_DW-1:0]   cfg_data,
  output      spef_pkg::spef_pat_t           pat
);

  import spef_pkg::*;

  logic [4:0]        pattern_len;
  logic [CFG_DW-1:0] pattern_low;
  logic [CFG_DW-1:0] pattern_high;
  logic [4:0]        eff_len;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_len  <= 5'd1;
      pattern_low  <= '0;
      pattern_high <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LEN:  pattern_len  <= cfg_data[4:0];
        CFG_LOW:  pattern_low  <= cfg_data;
        CFG_HIGH: pattern_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero length counts as one, long lengths saturate at the cap
  always_comb begin
    eff_len = (pattern_len == 5'd0) ? 5'd1 : pattern_len;
    if (eff_len > 5'(PAT_CAP)) begin
      eff_len = 5'(PAT_CAP);
    end
    pat.last  = 4'(eff_len - 5'd1);
    pat.bytes = {pattern_high, pattern_low};
  end

endmodule

`default_nettype wire

/* rtl/stream_pattern_explosion_filter_core.sv */
// ----------------------------------------------------------------------------
// Stream pattern explosion filter - top level
// Stack of symbols in a RAM; a push that ends with the pattern pops it.
//
//   channel  | signals                               | handshake
//   ---------+---------------------------------------+-----------------------
//   command  | item (mode, symbol, read_index)       | start, taken when !busy
//   result   | result (fill, read_symbol, flags)     | done, one-cycle strobe
//   config   | cfg_index, cfg_data                   | cfg_valid / cfg_ready
//
// Push, clear and no-op words give their result in the cycle after acceptance;
// a read gives it once the registered RAM data has passed the ST_RD state. A push
// whose symbol matches the last pattern byte reads the other n-1 candidate bytes
// from the RAM one per cycle through its single read port.
// One word is in flight at a time; busy is high while it is worked.
// Synchronous reset empties the stack at once; the RAM needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_pattern_explosion_filter_core #(
  parameter int unsigned STACK_DEPTH = spef_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output      logic                        busy,
  input  wire spef_pkg::spef_in_t          item,
  output      logic                        done,
  output      spef_pkg::spef_out_t         result,
  input  wire logic                        cfg_valid,
  output      logic                        cfg_ready,
  input  wire logic [spef_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [spef_pkg::CFG_DW-1:0] cfg_data
);

  import spef_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned FW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned CW = (FW > 12) ? FW : 12;

  spef_pat_t   pat;
  spef_state_t state, state_next;
  logic [FW-1:0] fill, fill_next;
  logic [FW-1:0] base, base_next;
  logic [3:0]    iss, iss_next;
  logic [3:0]    chk, chk_next;
  logic          pend, pend_next;
  logic          done_next;
  spef_out_t     result_next;

  logic          we;
  logic [AW-1:0] waddr;
  logic          re;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  logic [CW-1:0] idx_ext;

  spef_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pat       (pat)
  );

  // reads during a compare only touch entries below the last write,
  // and writes happen only when idle, so no forwarding is needed
  spef_ram #(
    .WIDTH (8),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (item.symbol),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign busy    = (state != ST_IDLE);
  assign idx_ext = CW'(item.read_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill  <= '0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      pend  <= pend_next;
      done  <= done_next;
    end
    base   <= base_next;
    iss    <= iss_next;
    chk    <= chk_next;
    result <= result_next;
  end

  always_comb begin
    state_next  = state;
    fill_next   = fill;
    base_next   = base;
    iss_next    = iss;
    chk_next    = chk;
    pend_next   = 1'b0;
    done_next   = 1'b0;
    result_next = result;
    we          = 1'b0;
    waddr       = fill[AW-1:0];
    re          = 1'b0;
    raddr       = base[AW-1:0] + AW'(iss);

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          result_next = '{fill: 13'(fill), read_symbol: 8'd0,
                          exploded: 1'b0, overflow: 1'b0};
          unique case (item.mode)
            MODE_PUSH: begin
              if (fill == FW'(STACK_DEPTH)) begin
                result_next.overflow = 1'b1;
                done_next            = 1'b1;
              end else begin
                we        = 1'b1;
                fill_next = fill + FW'(1);
                if (item.symbol == pat.bytes[pat.last] && fill >= FW'(pat.last)) begin
                  if (pat.last == 4'd0) begin
                    // single-byte pattern pops what was just pushed
                    fill_next            = fill;
                    result_next.exploded = 1'b1;
                    done_next            = 1'b1;
                  end else begin
                    base_next  = fill - FW'(pat.last);
                    iss_next   = 4'd0;
                    chk_next   = 4'd0;
                    state_next = ST_CMP;
                  end
                end else begin
                  result_next.fill = 13'(fill + FW'(1));
                  done_next        = 1'b1;
                end
              end
            end
            MODE_READ: begin
              if (idx_ext < CW'(fill)) begin
                re         = 1'b1;
                raddr      = idx_ext[AW-1:0];
                state_next = ST_RD;
              end else begin
                done_next = 1'b1;
              end
            end
            MODE_CLEAR: begin
              fill_next        = '0;
              result_next.fill = 13'd0;
              done_next        = 1'b1;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      ST_CMP: begin
        // issue one read a cycle, compare the one issued the cycle before
        re        = (iss < pat.last);
        pend_next = re;
        if (re) begin
          iss_next = iss + 4'd1;
        end
        if (pend) begin
          if (rdata != pat.bytes[chk]) begin
            result_next = '{fill: 13'(fill), read_symbol: 8'd0,
                            exploded: 1'b0, overflow: 1'b0};
            pend_next   = 1'b0;
            done_next   = 1'b1;
            state_next  = ST_IDLE;
          end else if (chk == pat.last - 4'd1) begin
            fill_next   = base;
            result_next = '{fill: 13'(base), read_symbol: 8'd0,
                            exploded: 1'b1, overflow: 1'b0};
            pend_next   = 1'b0;
            done_next   = 1'b1;
            state_next  = ST_IDLE;
          end else begin
            chk_next = chk + 4'd1;
          end
        end
      end

      ST_RD: begin
        result_next = '{fill: 13'(fill), read_symbol: rdata,
                        exploded: 1'b0, overflow: 1'b0};
        done_next   = 1'b1;
        state_next  = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/spef_checker.sv */
// ----------------------------------------------------------------------------
// Stream pattern explosion filter - port checker
// Watches the command and result ports of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stream_pattern_explosion_filter_core_defines.svh"

module spef_checker #(
  parameter int unsigned STACK_DEPTH = spef_pkg::STACK_DEPTH_DEF
) (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                done,
  input wire spef_pkg::spef_out_t result
);

  import spef_pkg::*;

  // an accepted word finishes at once or holds the block busy
  `SPEF_ASSERT_NXT(a_accept_progress, start && !busy, done || busy, "accepted word lost")

  // a result never coincides with an item still in work
  `SPEF_ASSERT_IMP(a_done_idle, done, !busy, "result while busy")

  // a result follows an acceptance or a busy cycle
  `SPEF_ASSERT_IMP(a_done_cause, done, $past(start && !busy) || $past(busy), "spurious result")

  // a dropped push leaves the stack full and pops nothing
  `SPEF_ASSERT_IMP(a_overflow_full, done && result.overflow,
    result.fill == 13'(STACK_DEPTH) && !result.exploded, "overflow with room left")

endmodule

bind stream_pattern_explosion_filter_core spef_checker #(
  .STACK_DEPTH (STACK_DEPTH)
) u_spef_checker (.*);

`default_nettype wire
